/* rtl/core/quoted_argument_tokenizer_assert.svh */
// Assertion helpers for the tokenizer modules (included by qat_emitter).
`ifndef QUOTED_ARGUMENT_TOKENIZER_ASSERT_SVH
`define QUOTED_ARGUMENT_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qat: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qat: next-cycle check failed");

`endif

/* rtl/core/qat_pkg.sv */
`timescale 1ns / 1ps

package qat_pkg;

    localparam int MaxResults = 4;
    localparam int CntW       = $clog2(MaxResults + 1);
    localparam int IdxW       = $clog2(MaxResults);

    localparam logic [7:0] ChSingle = 8'h27;
    localparam logic [7:0] ChDouble = 8'h22;
    localparam logic [7:0] ChBacksl = 8'h5C;
    localparam logic [7:0] ChSpace  = 8'h20;

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_SQUOTE = 3'd1,
        M_DQUOTE = 3'd2,
        M_ESC    = 3'd3,
        M_DQ_ESC = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        K_CHAR = 2'd0,
        K_WORD = 2'd1,
        K_LINE = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] chr;
    } t_result;

    typedef struct packed {
        t_result [MaxResults-1:0] ent;
        logic [CntW-1:0]          cnt;
    } t_res_list;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] chr;
        logic       last;
    } t_out;

endpackage

/* rtl/core/qat_lexer.sv */
`timescale 1ns / 1ps

// Lexer state and per-byte result list.
module qat_lexer
    import qat_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output t_res_list  o_list
);

    t_mode r_mode, n_mode;
    logic  r_word_open, n_word_open;

    // next state
    always_comb begin
        n_mode      = r_mode;
        n_word_open = r_word_open;
        unique case (r_mode)
            M_SQUOTE: begin
                if (i_ch == ChSingle) n_mode = M_NORMAL;
                else                  n_word_open = 1'b1;
            end
            M_DQUOTE: begin
                if (i_ch == ChDouble)                 n_mode = M_NORMAL;
                else if (i_ch == ChBacksl && !i_last) n_mode = M_DQ_ESC;
                else                                  n_word_open = 1'b1;
            end
            M_DQ_ESC: begin
                n_word_open = 1'b1;
                n_mode      = M_DQUOTE;
            end
            M_ESC: begin
                n_word_open = 1'b1;
                n_mode      = M_NORMAL;
            end
            default: begin
                n_mode = M_NORMAL;
                if (i_ch == ChSingle)      n_mode = M_SQUOTE;
                else if (i_ch == ChDouble) n_mode = M_DQUOTE;
                else if (i_ch == ChBacksl) n_mode = M_ESC;
                else if (i_ch == ChSpace)  n_word_open = 1'b0;
                else                       n_word_open = 1'b1;
            end
        endcase
        if (i_last) begin
            n_mode      = M_NORMAL;
            n_word_open = 1'b0;
        end
    end

    // result list
    always_comb begin
        logic [CntW-1:0] n;
        logic            open;
        o_list = '0;
        n      = '0;
        open   = r_word_open;
        unique case (r_mode)
            M_SQUOTE: begin
                if (i_ch != ChSingle) begin
                    o_list.ent[n[IdxW-1:0]].kind = K_CHAR;
                    o_list.ent[n[IdxW-1:0]].chr  = i_ch;
                    n    = n + 1'b1;
                    open = 1'b1;
                end
            end
            M_DQUOTE: begin
                if (i_ch != ChDouble && !(i_ch == ChBacksl && !i_last)) begin
                    o_list.ent[n[IdxW-1:0]].kind = K_CHAR;
                    o_list.ent[n[IdxW-1:0]].chr  = i_ch;
                    n    = n + 1'b1;
                    open = 1'b1;
                end
            end
            M_DQ_ESC: begin
                // backslash kept unless it escapes a double quote or backslash
                if (i_ch != ChDouble && i_ch != ChBacksl) begin
                    o_list.ent[n[IdxW-1:0]].kind = K_CHAR;
                    o_list.ent[n[IdxW-1:0]].chr  = ChBacksl;
                    n = n + 1'b1;
                end
                o_list.ent[n[IdxW-1:0]].kind = K_CHAR;
                o_list.ent[n[IdxW-1:0]].chr  = i_ch;
                n    = n + 1'b1;
                open = 1'b1;
            end
            M_ESC: begin
                o_list.ent[n[IdxW-1:0]].kind = K_CHAR;
                o_list.ent[n[IdxW-1:0]].chr  = i_ch;
                n    = n + 1'b1;
                open = 1'b1;
            end
            default: begin
                if (i_ch == ChSpace) begin
                    if (open) begin
                        o_list.ent[n[IdxW-1:0]].kind = K_WORD;
                        n    = n + 1'b1;
                        open = 1'b0;
                    end
                end else if (i_ch != ChSingle && i_ch != ChDouble && i_ch != ChBacksl) begin
                    o_list.ent[n[IdxW-1:0]].kind = K_CHAR;
                    o_list.ent[n[IdxW-1:0]].chr  = i_ch;
                    n    = n + 1'b1;
                    open = 1'b1;
                end
            end
        endcase
        if (i_last) begin
            if (open) begin
                o_list.ent[n[IdxW-1:0]].kind = K_WORD;
                n = n + 1'b1;
            end
            o_list.ent[n[IdxW-1:0]].kind = K_LINE;
            n = n + 1'b1;
        end
        o_list.cnt = n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_NORMAL;
            r_word_open <= 1'b0;
        end else if (i_accept) begin
            r_mode      <= n_mode;
            r_word_open <= n_word_open;
        end
    end

endmodule

/* rtl/core/qat_emitter.sv */
`timescale 1ns / 1ps
`include "quoted_argument_tokenizer_assert.svh"

// Result buffer for one byte's list, drained one result a cycle into the
// output register while that register is free.
module qat_emitter
    import qat_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_res_list i_list,
    output logic      o_ready,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out      o_out
);

    t_result [MaxResults-1:0] r_ent, n_ent;
    logic [CntW-1:0]          r_cnt, n_cnt;
    logic                     r_out_vld;
    t_out                     r_out;
    logic                     out_free;
    logic                     move;

    assign out_free = !r_out_vld || i_out_ready;
    assign move     = out_free && (r_cnt != '0);
    assign o_ready  = (r_cnt == '0) || ((r_cnt == CntW'(1)) && out_free);

    always_comb begin
        n_ent = r_ent;
        n_cnt = r_cnt;
        if (i_load) begin
            n_ent = i_list.ent;
            n_cnt = i_list.cnt;
        end else if (move) begin
            for (int i = 0; i < MaxResults - 1; i++) begin
                n_ent[i] = r_ent[i+1];
            end
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (out_free) r_out_vld <= (r_cnt != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        if (move) begin
            r_out.kind <= r_ent[0].kind;
            r_out.chr  <= r_ent[0].chr;
            r_out.last <= (r_cnt == CntW'(1));
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    `QAT_ASSERT_IMP(a_load_when_drained, i_clk, i_rst_n, i_load, (r_cnt == '0) || ((r_cnt == CntW'(1)) && out_free))
    `QAT_ASSERT_IMP(a_cnt_bounded, i_clk, i_rst_n, 1'b1, r_cnt <= CntW'(MaxResults))
    `QAT_ASSERT_IMP(a_more_follows, i_clk, i_rst_n, r_out_vld && i_out_ready && !r_out.last, r_cnt != '0)
    `QAT_ASSERT_NXT(a_drain_step, i_clk, i_rst_n, move && !i_load, r_cnt == $past(r_cnt) - 1'b1)

endmodule

/* rtl/core/quoted_argument_tokenizer.sv */
`timescale 1ns / 1ps

// Shell-style word splitter for a byte stream. Each slave transaction carries
// one command-line byte, with tlast on the final byte of the line. Each master
// transaction carries one result: tuser gives the kind (character appended,
// word end, line done), tdata the appended character (zero for the other
// kinds), and tlast marks the final result caused by one input byte. Spaces
// split words outside quotes, backslash escapes the next byte, single quotes
// are fully literal, and inside double quotes a backslash only escapes a
// double quote or a backslash. A byte giving no result still takes one
// transaction and may change the quoting state. Throughput: one byte per cycle
// while each byte gives at most one result and m_axis_tready stays high; a
// byte giving several results (up to four) holds the input until they drain,
// as results leave the single output register one per cycle while the master
// side is ready. A byte is taken even while the previous result waits on the
// master side. A byte's result goes via the buffer, then the output register.
module quoted_argument_tokenizer
    import qat_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    input  logic       s_axis_tlast,   // line_end

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast    // run_last
);

    logic      accept;
    t_res_list res_list;
    t_out      out_res;

    // byte taken only when the result buffer has room for its whole list
    assign accept = s_axis_tvalid && s_axis_tready;

    qat_lexer u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_ch     (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_list   (res_list)
    );

    qat_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_list      (res_list),
        .o_ready     (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out       (out_res)
    );

    assign m_axis_tdata = out_res.chr;
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule
